### hw/rtl/bcg_pkg.sv
// bcg_pkg: shared types and constants for the button click gesture detector
// used by bcg_lane, bcg_merge and button_click_gesture_detector_unit
// no dependencies
`default_nettype none

package bcg_pkg;

    // fixed field widths of the ports
    localparam int FIELD_W   = 5;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 8;

    // parameter defaults
    localparam int NUM_BUTTONS_DEF = 5;
    localparam int TICK_WIDTH_DEF  = 16;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLICK      = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_GAP = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASED   = 8'd3;

    // register reset values
    localparam logic [CFG_W-1:0] DEBOUNCE_RESET   = 16'd20;
    localparam logic [CFG_W-1:0] CLICK_RESET      = 16'd1000;
    localparam logic [CFG_W-1:0] DOUBLE_GAP_RESET = 16'd100;
    localparam logic             RELEASED_RESET   = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE       = 4'd0,
        ST_PRESSED    = 4'd1,
        ST_LONG_START = 4'd2,
        ST_LONG_HOLD  = 4'd3,
        ST_RELEASED   = 4'd4,
        ST_REPORT     = 4'd5,
        ST_GAP        = 4'd6,
        ST_SECOND     = 4'd7,
        ST_DOUBLE     = 4'd8
    } t_gest_state;

    typedef struct packed {
        logic [CFG_W-1:0] debounce;
        logic [CFG_W-1:0] click;
        logic [CFG_W-1:0] double_gap;
        logic             released;
    } t_lane_cfg;

    typedef struct packed {
        logic long_start;
        logic one_click;
        logic long_end;
        logic two_click;
    } t_lane_ev;

endpackage

`default_nettype wire

### hw/rtl/bcg_lane.sv
// bcg_lane: debounce counter and gesture state machine of one button
// depends on bcg_pkg
`default_nettype none

module bcg_lane import bcg_pkg::*; #(
    parameter int TICK_WIDTH = TICK_WIDTH_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_step,
    input  wire logic      i_level,
    input  wire t_lane_cfg i_cfg,
    output t_lane_ev       o_ev
);

    localparam int CMP_W = (TICK_WIDTH > CFG_W) ? TICK_WIDTH : CFG_W;

    t_gest_state           r_state, n_state;
    logic                  r_last, n_last;
    logic [TICK_WIDTH-1:0] r_hold, n_hold;
    logic [TICK_WIDTH-1:0] r_meas, n_meas;

    logic [TICK_WIDTH-1:0] w_hold_inc;
    logic [TICK_WIDTH-1:0] w_meas_press;
    logic [CMP_W-1:0]      w_inc_x, w_meas_press_x, w_meas_x;
    logic [CMP_W-1:0]      w_deb_x, w_click_x, w_gap_x;
    logic                  w_rel;

    // saturating hold counter
    assign w_hold_inc = (r_hold == {TICK_WIDTH{1'b1}}) ? r_hold
                      : r_hold + {{(TICK_WIDTH-1){1'b0}}, 1'b1};
    assign w_rel        = (i_level == i_cfg.released);
    assign w_meas_press = w_rel ? r_meas : w_hold_inc;

    assign w_inc_x        = CMP_W'(w_hold_inc);
    assign w_meas_press_x = CMP_W'(w_meas_press);
    assign w_meas_x       = CMP_W'(r_meas);
    assign w_deb_x        = CMP_W'(i_cfg.debounce);
    assign w_click_x      = CMP_W'(i_cfg.click);
    assign w_gap_x        = CMP_W'(i_cfg.double_gap);

    always_comb begin
        n_state = r_state;
        n_last  = r_last;
        n_hold  = r_hold;
        n_meas  = r_meas;
        o_ev    = '0;
        if (i_level != r_last) begin
            // level change restarts the hold count, machine waits
            n_last = i_level;
            n_hold = {{(TICK_WIDTH-1){1'b0}}, 1'b1};
        end else begin
            n_hold = w_hold_inc;
            if (w_inc_x > w_deb_x) begin
                unique case (r_state)
                    ST_IDLE: begin
                        if (!w_rel) n_state = ST_PRESSED;
                    end
                    ST_PRESSED: begin
                        n_meas = w_meas_press;
                        // long press wins over release
                        if (w_meas_press_x > w_click_x) n_state = ST_LONG_START;
                        else if (w_rel)                 n_state = ST_RELEASED;
                    end
                    ST_LONG_START: begin
                        o_ev.long_start = 1'b1;
                        n_state         = ST_LONG_HOLD;
                    end
                    ST_LONG_HOLD: begin
                        if (w_rel) n_state = ST_RELEASED;
                        else       n_meas  = w_hold_inc;
                    end
                    ST_RELEASED: begin
                        n_state = (w_meas_x < w_click_x) ? ST_GAP : ST_REPORT;
                    end
                    ST_REPORT: begin
                        if (w_meas_x < w_click_x) o_ev.one_click = 1'b1;
                        else                      o_ev.long_end  = 1'b1;
                        n_meas  = '0;
                        n_hold  = '0;
                        n_state = ST_IDLE;
                    end
                    ST_GAP: begin
                        if (w_rel) begin
                            n_meas = w_hold_inc;
                            if (w_inc_x > w_gap_x) n_state = ST_REPORT;
                        end else begin
                            n_state = ST_SECOND;
                        end
                    end
                    ST_SECOND: begin
                        if (w_rel) n_state = ST_DOUBLE;
                        else       n_meas  = w_hold_inc;
                    end
                    ST_DOUBLE: begin
                        o_ev.two_click = 1'b1;
                        n_hold         = '0;
                        n_state        = ST_IDLE;
                    end
                    default: begin
                        n_state = ST_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_last  <= RELEASED_RESET;
            r_hold  <= '0;
            r_meas  <= '0;
        end else if (i_step) begin
            r_state <= n_state;
            r_last  <= n_last;
            r_hold  <= n_hold;
            r_meas  <= n_meas;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/bcg_merge.sv
// bcg_merge: gathers lane events into result vectors, output register plus skid
// depends on bcg_pkg
`default_nettype none

module bcg_merge import bcg_pkg::*; #(
    parameter int NUM_BUTTONS = NUM_BUTTONS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire t_lane_ev           i_lane_ev [NUM_BUTTONS],
    output logic                    o_stall,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [FIELD_W-1:0]      o_long_start,
    output logic [FIELD_W-1:0]      o_one_click,
    output logic [FIELD_W-1:0]      o_long_end,
    output logic [FIELD_W-1:0]      o_two_click
);

    localparam int OUT_LANES = (NUM_BUTTONS < FIELD_W) ? NUM_BUTTONS : FIELD_W;
    localparam int RES_W     = 4 * FIELD_W;

    logic [FIELD_W-1:0] w_ls, w_sc, w_le, w_dc;
    logic [RES_W-1:0]   w_res;
    logic [RES_W-1:0]   r_out, r_skid;
    logic               r_out_valid, r_skid_valid;
    logic               w_pop;

    always_comb begin
        w_ls = '0;
        w_sc = '0;
        w_le = '0;
        w_dc = '0;
        for (int i = 0; i < OUT_LANES; i++) begin
            w_ls[i] = i_lane_ev[i].long_start;
            w_sc[i] = i_lane_ev[i].one_click;
            w_le[i] = i_lane_ev[i].long_end;
            w_dc[i] = i_lane_ev[i].two_click;
        end
    end

    assign w_res = {w_ls, w_sc, w_le, w_dc};
    assign w_pop = r_out_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || w_pop) begin
            // output slot frees: skid first, else the new item
            r_out_valid  <= r_skid_valid || i_push;
            r_skid_valid <= 1'b0;
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || w_pop) begin
            r_out <= r_skid_valid ? r_skid : w_res;
        end
        if (i_push && r_out_valid && !w_pop) begin
            r_skid <= w_res;
        end
    end

    assign o_stall      = r_skid_valid;
    assign o_valid      = r_out_valid;
    assign o_long_start = r_out[4*FIELD_W-1:3*FIELD_W];
    assign o_one_click  = r_out[3*FIELD_W-1:2*FIELD_W];
    assign o_long_end   = r_out[2*FIELD_W-1:FIELD_W];
    assign o_two_click  = r_out[FIELD_W-1:0];

endmodule

`default_nettype wire

### hw/rtl/button_click_gesture_detector_unit.sv
// button_click_gesture_detector_unit: top level, config registers, lanes, merge
// depends on bcg_pkg, bcg_lane, bcg_merge
// each accepted tick's result is registered, in the skid slot if output is held
// throughput: one item per clock while the skid slot is empty
// reset: synchronous active-low; registers return to their defaults and
//   every button to idle, released level, counters at zero
`default_nettype none

module button_click_gesture_detector_unit import bcg_pkg::*; #(
    parameter int NUM_BUTTONS = NUM_BUTTONS_DEF,
    parameter int TICK_WIDTH  = TICK_WIDTH_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // tick items
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic [FIELD_W-1:0]   i_pin_levels,
    // result items
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output logic [FIELD_W-1:0]        o_long_start_events,
    output logic [FIELD_W-1:0]        o_one_click_events,
    output logic [FIELD_W-1:0]        o_long_end_events,
    output logic [FIELD_W-1:0]        o_two_click_events,
    // configuration writes
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data
);

    t_lane_cfg r_cfg;
    t_lane_ev  w_lane_ev [NUM_BUTTONS];
    logic      w_accept;

    // register writes are always accepted
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce   <= DEBOUNCE_RESET;
            r_cfg.click      <= CLICK_RESET;
            r_cfg.double_gap <= DOUBLE_GAP_RESET;
            r_cfg.released   <= RELEASED_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_DEBOUNCE:   r_cfg.debounce   <= i_cfg_data;
                CFG_CLICK:      r_cfg.click      <= i_cfg_data;
                CFG_DOUBLE_GAP: r_cfg.double_gap <= i_cfg_data;
                CFG_RELEASED:   r_cfg.released   <= i_cfg_data[0];
                default: begin
                    // writes to unknown indexes are dropped
                end
            endcase
        end
    end

    // a tick item is taken whenever the skid slot is empty
    assign w_accept = i_in_valid && !o_in_stall;

    // one lane per button; buttons past the pin field see a constant low level
    for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_lane
        logic w_level;
        if (g < FIELD_W) begin : g_pin
            assign w_level = i_pin_levels[g];
        end else begin : g_nopin
            assign w_level = 1'b0;
        end
        bcg_lane #(
            .TICK_WIDTH (TICK_WIDTH)
        ) u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_step  (w_accept),
            .i_level (w_level),
            .i_cfg   (r_cfg),
            .o_ev    (w_lane_ev[g])
        );
    end

    // event gathering and output buffering
    bcg_merge #(
        .NUM_BUTTONS (NUM_BUTTONS)
    ) u_merge (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_accept),
        .i_lane_ev    (w_lane_ev),
        .o_stall      (o_in_stall),
        .o_valid      (o_out_valid),
        .i_stall      (i_out_stall),
        .o_long_start (o_long_start_events),
        .o_one_click  (o_one_click_events),
        .o_long_end   (o_long_end_events),
        .o_two_click  (o_two_click_events)
    );

    // skid slot only fills behind a full output register
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("skid holds an item while output register is empty");

    // every accepted tick leaves the output valid next cycle
    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_out_valid)
        else $error("accepted item produced no result");

    // skid fills only when the consumer held the output
    a_skid_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_in_stall) |-> $past(i_out_stall))
        else $error("skid filled without a downstream stall");

    // a button gives at most one event per tick
    a_events_disjoint: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_long_start_events & o_one_click_events) == '0
            && (o_long_start_events & o_long_end_events) == '0
            && (o_long_start_events & o_two_click_events) == '0
            && (o_one_click_events & o_long_end_events) == '0
            && (o_one_click_events & o_two_click_events) == '0
            && (o_long_end_events & o_two_click_events) == '0))
        else $error("one button reported two events in a tick");

endmodule

`default_nettype wire

### verif/tb_button_click_gesture_detector_unit.sv
// testbench for button_click_gesture_detector_unit: random press/release timing per button,
// an in-bench gesture predictor and a scoreboard that checks every result item
// depends on bcg_pkg and the button_click_gesture_detector_unit rtl
`timescale 1ns / 100ps

module tb_button_click_gesture_detector_unit;
    import bcg_pkg::*;

    localparam int NB               = NUM_BUTTONS_DEF;
    localparam int TICK_W           = TICK_WIDTH_DEF;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int WATCHDOG_LIMIT   = 5000;
    // index that maps to no register, writes to it must change nothing
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 8'hFF;

    typedef struct packed {
        logic [FIELD_W-1:0] long_start;
        logic [FIELD_W-1:0] one_click;
        logic [FIELD_W-1:0] long_end;
        logic [FIELD_W-1:0] two_click;
    } t_button_events;

    // clock, reset and dut ports; the bench-driven ones are known from time zero
    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic [FIELD_W-1:0]   i_pin_levels = '1;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [FIELD_W-1:0]   o_long_start_events;
    logic [FIELD_W-1:0]   o_one_click_events;
    logic [FIELD_W-1:0]   o_long_end_events;
    logic [FIELD_W-1:0]   o_two_click_events;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;

    always #10 i_clk = ~i_clk;

    button_click_gesture_detector_unit dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_pin_levels        (i_pin_levels),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_long_start_events (o_long_start_events),
        .o_one_click_events  (o_one_click_events),
        .o_long_end_events   (o_long_end_events),
        .o_two_click_events  (o_two_click_events),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data)
    );

    // ------------------------------------------------------------------
    // gesture predictor: own copy of registers and per-button state
    // ------------------------------------------------------------------
    logic [CFG_W-1:0]  cfg_debounce   = DEBOUNCE_RESET;
    logic [CFG_W-1:0]  cfg_click      = CLICK_RESET;
    logic [CFG_W-1:0]  cfg_double_gap = DOUBLE_GAP_RESET;
    logic              cfg_released   = RELEASED_RESET;

    t_gest_state       btn_state    [NB];
    logic              btn_level    [NB];
    logic [TICK_W-1:0] btn_hold     [NB];
    logic [TICK_W-1:0] btn_measured [NB];

    initial begin
        for (int b = 0; b < NB; b++) begin
            btn_state[b]    = ST_IDLE;
            btn_level[b]    = RELEASED_RESET;
            btn_hold[b]     = '0;
            btn_measured[b] = '0;
        end
    end

    // advance every button by one tick and collect the event pulses
    function automatic t_button_events step_buttons(input logic [FIELD_W-1:0] pins);
        t_button_events ev;
        logic           lvl;
        logic           rel;
        ev = '0;
        for (int b = 0; b < NB; b++) begin
            lvl = pins[b];
            rel = (lvl == cfg_released);
            if (lvl != btn_level[b]) begin
                // any edge restarts the hold count and skips this button for the tick
                btn_level[b] = lvl;
                btn_hold[b]  = TICK_W'(1);
            end else begin
                if (btn_hold[b] != '1)
                    btn_hold[b] = btn_hold[b] + 1'b1;
                if (btn_hold[b] > cfg_debounce) begin
                    case (btn_state[b])
                        ST_IDLE: begin
                            if (!rel)
                                btn_state[b] = ST_PRESSED;
                        end
                        ST_PRESSED: begin
                            if (rel)
                                btn_state[b] = ST_RELEASED;
                            else
                                btn_measured[b] = btn_hold[b];
                            // long press wins over the release move
                            if (btn_measured[b] > cfg_click)
                                btn_state[b] = ST_LONG_START;
                        end
                        ST_LONG_START: begin
                            ev.long_start[b] = 1'b1;
                            btn_state[b] = ST_LONG_HOLD;
                        end
                        ST_LONG_HOLD: begin
                            if (rel)
                                btn_state[b] = ST_RELEASED;
                            else
                                btn_measured[b] = btn_hold[b];
                        end
                        ST_RELEASED: begin
                            btn_state[b] = (btn_measured[b] < cfg_click) ? ST_GAP : ST_REPORT;
                        end
                        ST_REPORT: begin
                            if (btn_measured[b] < cfg_click)
                                ev.one_click[b] = 1'b1;
                            else
                                ev.long_end[b] = 1'b1;
                            btn_measured[b] = '0;
                            btn_hold[b]     = '0;
                            btn_state[b]    = ST_IDLE;
                        end
                        ST_GAP: begin
                            if (rel) begin
                                btn_measured[b] = btn_hold[b];
                                if (btn_measured[b] > cfg_double_gap)
                                    btn_state[b] = ST_REPORT;
                            end else begin
                                btn_state[b] = ST_SECOND;
                            end
                        end
                        ST_SECOND: begin
                            if (rel)
                                btn_state[b] = ST_DOUBLE;
                            else
                                btn_measured[b] = btn_hold[b];
                        end
                        ST_DOUBLE: begin
                            ev.two_click[b] = 1'b1;
                            btn_hold[b]  = '0;
                            btn_state[b] = ST_IDLE;
                        end
                        default: begin
                            btn_state[b] = ST_IDLE;
                        end
                    endcase
                end
            end
        end
        return ev;
    endfunction

    // ------------------------------------------------------------------
    // stimulus queues, idling knobs and counters
    // ------------------------------------------------------------------
    logic [FIELD_W-1:0] pending_pins [$];
    t_button_events     expected_events [$];
    int                 sender_idle_pct = 0;
    int                 receiver_stall_pct = 0;
    int                 hold_requests = 0;
    int                 hold_served = 0;
    int                 hold_cycles_left = 0;
    int                 mismatch_count = 0;
    int                 quiet_cycles = 0;

    // per-button level generator state
    logic               gen_level [NB];
    int                 gen_left  [NB];

    // driver: next tick item goes out once the current one is taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || !o_in_stall) begin
            if (pending_pins.size() != 0 && $urandom_range(99, 0) >= sender_idle_pct) begin
                i_in_valid   <= 1'b1;
                i_pin_levels <= pending_pins.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver stall: a requested long hold-off first, random stalls otherwise
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_cycles_left != 0) begin
            i_out_stall      <= 1'b1;
            hold_cycles_left <= hold_cycles_left - 1;
        end else if (hold_served != hold_requests) begin
            hold_served      <= hold_served + 1;
            hold_cycles_left <= LONG_HOLD_CYCLES;
            i_out_stall      <= 1'b1;
        end else begin
            i_out_stall <= (receiver_stall_pct != 0) &&
                           ($urandom_range(99, 0) < receiver_stall_pct);
        end
    end

    task automatic check_field(input string name, input logic [FIELD_W-1:0] want,
                               input logic [FIELD_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %b actual %b", $realtime, name, want, got);
            mismatch_count++;
        end
    endtask

    // monitor: check the result item first, then predict from the tick item
    always @(posedge i_clk) begin : monitor
        t_button_events want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_events.size() == 0) begin
                    $display("%0t: result item with nothing expected, expected none actual %b %b %b %b",
                             $realtime, o_long_start_events, o_one_click_events,
                             o_long_end_events, o_two_click_events);
                    mismatch_count++;
                end else begin
                    want = expected_events.pop_front();
                    check_field("long_start", want.long_start, o_long_start_events);
                    check_field("one_click", want.one_click, o_one_click_events);
                    check_field("long_end", want.long_end, o_long_end_events);
                    check_field("two_click", want.two_click, o_two_click_events);
                end
            end
            if (i_in_valid && !o_in_stall)
                expected_events.push_back(step_buttons(i_pin_levels));
        end
    end

    // watchdog on cycles with no handshake of any kind
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired, no handshake for %0d cycles",
                     $realtime, WATCHDOG_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // sequencing helpers
    // ------------------------------------------------------------------

    // write one register and mirror it in the predictor at the handshake
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do
            @(posedge i_clk);
        while (o_cfg_ready !== 1'b1);
        case (idx)
            CFG_DEBOUNCE:   cfg_debounce   = data;
            CFG_CLICK:      cfg_click      = data;
            CFG_DOUBLE_GAP: cfg_double_gap = data;
            CFG_RELEASED:   cfg_released   = data[0];
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
    endtask

    task automatic write_all(input logic [CFG_W-1:0] debounce, input logic [CFG_W-1:0] click,
                             input logic [CFG_W-1:0] gap, input logic [CFG_W-1:0] released);
        write_reg(CFG_DEBOUNCE, debounce);
        write_reg(CFG_CLICK, click);
        write_reg(CFG_DOUBLE_GAP, gap);
        write_reg(CFG_RELEASED, released);
    endtask

    // mode 0 no idling, 1 sender idles, 2 receiver stalls, 3 both a little
    task automatic set_idling(input int mode);
        case (mode)
            1:       begin sender_idle_pct = 67; receiver_stall_pct = 0;  end
            2:       begin sender_idle_pct = 0;  receiver_stall_pct = 67; end
            3:       begin sender_idle_pct = 22; receiver_stall_pct = 22; end
            default: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        endcase
    endtask

    // block until every tick is sent and every result has come back
    task automatic wait_drained();
        while (pending_pins.size() != 0 || i_in_valid || expected_events.size() != 0)
            @(posedge i_clk);
    endtask

    // press/release runs per button, lengths sized around the current timing
    // registers up to a cap, so small ones let clicks, long presses, double clicks complete
    task automatic queue_gesture_ticks(input int count);
        int                 span;
        int                 db;
        int                 r;
        int                 len;
        int                 glitch;
        logic [FIELD_W-1:0] pins;
        db = cfg_debounce;
        if (db > 3)
            db = 3;
        span = cfg_debounce + cfg_click + cfg_double_gap + 6;
        if (span > 40)
            span = 40;
        for (int n = 0; n < count; n++) begin
            for (int b = 0; b < NB; b++) begin
                if (gen_left[b] == 0) begin
                    gen_level[b] = ~gen_level[b];
                    r = $urandom_range(99, 0);
                    if (r < 15)
                        len = $urandom_range(1, db + 1);         // contact bounce
                    else if (r < 85)
                        len = $urandom_range(db + 1, span);      // click and gap window
                    else
                        len = $urandom_range(span, 3 * span);    // long press or idle
                    gen_left[b] = len;
                end
                gen_left[b]--;
                pins[b] = gen_level[b];
            end
            // single-tick glitch on one pin
            if ($urandom_range(99, 0) < 5) begin
                glitch = $urandom_range(NB - 1, 0);
                pins[glitch] = ~pins[glitch];
            end
            pending_pins.push_back(pins);
        end
    endtask

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    logic [FIELD_W-1:0] directed_pins [24] = '{
        5'b11111, 5'b00000, 5'b00000, 5'b00000, 5'b00000, 5'b00000, 5'b00000, 5'b11111,
        5'b11111, 5'b11111, 5'b11111, 5'b11110, 5'b11110, 5'b11111, 5'b11111, 5'b11111,
        5'b11110, 5'b11110, 5'b11111, 5'b11111, 5'b11111, 5'b01010, 5'b10101, 5'b11111
    };

    initial begin
        for (int b = 0; b < NB; b++) begin
            gen_level[b] = 1'b1;
            gen_left[b]  = 0;
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset values of the registers, nothing much fires at these times
        set_idling(0);
        queue_gesture_ticks(40);
        wait_drained();

        // directed: all pins at both extremes, long press on all buttons,
        // then click attempts on one button, zero debounce
        write_all(16'd0, 16'd3, 16'd2, 16'd1);
        foreach (directed_pins[k])
            pending_pins.push_back(directed_pins[k]);
        wait_drained();

        // short timing, sender idling
        write_all(16'd1, 16'd6, 16'd4, 16'd1);
        set_idling(1);
        queue_gesture_ticks(150);
        wait_drained();

        // released level low: the stored last level is left as it was;
        // receiver stalls plus one long hold-off while ticks keep coming
        write_all(16'd2, 16'd10, 16'd6, 16'd0);
        set_idling(2);
        queue_gesture_ticks(150);
        while (pending_pins.size() > 100)
            @(posedge i_clk);
        hold_requests++;
        wait_drained();

        // zero click and gap times
        write_all(16'd3, 16'd0, 16'd0, 16'd1);
        set_idling(3);
        queue_gesture_ticks(100);
        wait_drained();

        // all times at their maximum, plus a write to an unmapped index
        write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFE);
        write_reg(CFG_UNUSED, 16'hFFFF);
        queue_gesture_ticks(40);
        wait_drained();

        // random small timing, no idling, another long hold-off
        write_all(CFG_W'($urandom_range(3, 0)), CFG_W'($urandom_range(12, 0)),
                  CFG_W'($urandom_range(10, 0)), CFG_W'($urandom_range(65535, 0)));
        set_idling(0);
        queue_gesture_ticks(150);
        while (pending_pins.size() > 80)
            @(posedge i_clk);
        hold_requests++;
        wait_drained();

        // let any stray result item show up before the verdict
        repeat (4) @(posedge i_clk);
        if (mismatch_count == 0 && expected_events.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
